### design/rect_pack_guillotine_best_area_unit_defines.svh
// assertion macros for the rectangle packer
`ifndef RECT_PACK_GUILLOTINE_BEST_AREA_UNIT_DEFINES_SVH
`define RECT_PACK_GUILLOTINE_BEST_AREA_UNIT_DEFINES_SVH
// implication checked every clock outside reset
`define RPG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define RPG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/rpg_pkg.sv
// shared constants and types for the rectangle packer
package rpg_pkg;
    localparam int MaxRects = 64;
    localparam int MaxSlots = 128;
    localparam int DimBits  = 10;
    localparam int RidxW    = $clog2(MaxRects);
    localparam int RcntW    = $clog2(MaxRects + 1);
    localparam int SidxW    = $clog2(MaxSlots);
    localparam int ScntW    = $clog2(MaxSlots + 1);
    localparam int QDepth   = 2;

    typedef struct packed {
        logic [9:0] w;
        logic [9:0] h;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [5:0]  idx;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] aw;
        logic [15:0] ah;
        logic        ovf;
        logic        last;
    } t_result;

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction
endpackage

### design/rpg_ram.sv
// generic single-port-write ram with registered read
module rpg_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/rpg_front.sv
// input front: masks sizes and queues items for the packer core
module rpg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [9:0]           i_w,
    input  logic [9:0]           i_h,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rpg_pkg::t_item       o_item
);
    rpg_pkg::t_item r_q [rpg_pkg::QDepth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    logic [9:0] dmask;

    assign dmask   = 10'((11'd1 << rpg_pkg::DimBits) - 11'd1);
    assign o_ready = (r_cnt != 2'(rpg_pkg::QDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{w: i_w & dmask, h: i_h & dmask, last: i_last};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    `include "rect_pack_guillotine_best_area_unit_defines.svh"
    `RPG_ASSERT_IMP(a_no_overfill, r_cnt == 2'(rpg_pkg::QDepth), !push)
    `RPG_ASSERT_NXT(a_cnt_up, push && !pop, r_cnt == $past(r_cnt) + 2'd1)
    `RPG_ASSERT_NXT(a_cnt_down, pop && !push, r_cnt == $past(r_cnt) - 2'd1)
endmodule

### design/rpg_core.sv
// packer core: stores, sorts, scans free slots and places rectangles
module rpg_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rpg_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output rpg_pkg::t_result  o_res
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SORT_RD = 4'd1, S_SORT_CMP = 4'd2,
        S_SORT_WR = 4'd3, S_INIT = 4'd4, S_INIT2 = 4'd5, S_RECT = 4'd6,
        S_RECT2 = 4'd7, S_SCAN = 4'd8, S_DEC = 4'd9, S_SHIFT = 4'd10,
        S_PUSH = 4'd11, S_OUT = 4'd12, S_SHIFT2 = 4'd13, S_BOOT = 4'd14,
        S_RECT3 = 4'd15;
    localparam int RW = rpg_pkg::RidxW;
    localparam int SW = rpg_pkg::SidxW;
    localparam int NW = rpg_pkg::ScntW;

    logic [3:0] r_st;
    logic [rpg_pkg::RcntW-1:0] r_cnt, r_i, r_j, r_k;
    logic [19:0] r_akey;
    logic [rpg_pkg::ScntW-1:0] r_scnt, r_si, r_best;
    logic [31:0] r_barea;
    logic r_found, r_ovf;
    logic [15:0] r_bw, r_bh, r_rw, r_rh, r_px, r_py;
    logic [RW-1:0] r_id;
    logic [15:0] r_sx, r_sy, r_sw, r_sh;
    logic [1:0] r_pn, r_pi;
    logic [63:0] r_p0, r_p1;
    logic r_vout;
    rpg_pkg::t_result r_res;

    // rect ram
    logic re_we; logic [RW-1:0] re_wa, re_ra; logic [19:0] re_wd, re_rd;
    rpg_ram #(.Width(20), .Depth(rpg_pkg::MaxRects)) u_rects (
        .i_clk(i_clk), .i_we(re_we), .i_waddr(re_wa), .i_wdata(re_wd),
        .i_raddr(re_ra), .o_rdata(re_rd));
    // order ram
    logic or_we; logic [RW-1:0] or_wa, or_ra, or_wd, or_rd;
    rpg_ram #(.Width(RW), .Depth(rpg_pkg::MaxRects)) u_order (
        .i_clk(i_clk), .i_we(or_we), .i_waddr(or_wa), .i_wdata(or_wd),
        .i_raddr(or_ra), .o_rdata(or_rd));
    // slot ram: x,y,w,h
    logic sl_we; logic [SW-1:0] sl_wa, sl_ra; logic [63:0] sl_wd, sl_rd;
    rpg_ram #(.Width(64), .Depth(rpg_pkg::MaxSlots)) u_slots (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_wa), .i_wdata(sl_wd),
        .i_raddr(sl_ra), .o_rdata(sl_rd));

    logic [19:0] ld_area;
    assign ld_area = 20'(re_rd[19:10]) * 20'(re_rd[9:0]);
    assign o_ready = (r_st == S_IDLE) && !r_vout;
    assign o_valid = r_vout;
    assign o_res   = r_res;

    logic [16:0] ew, eh, sq_r, sq_b;
    assign ew   = 17'(r_bw) + 17'(r_rw);
    assign eh   = 17'(r_bh) + 17'(r_rh);
    assign sq_r = (ew > 17'(r_bh)) ? ew - 17'(r_bh) : 17'(r_bh) - ew;
    assign sq_b = (eh > 17'(r_bw)) ? eh - 17'(r_bw) : 17'(r_bw) - eh;

    logic [63:0] pend;
    assign pend = (r_pi == 2'd0) ? r_p0 : r_p1;

    logic [31:0] slot_area;
    assign slot_area = 32'(sl_rd[31:16]) * 32'(sl_rd[15:0]);

    logic boot_nz;
    assign boot_nz = (re_rd[19:10] != 10'd0) && (re_rd[9:0] != 10'd0);

    always_comb begin
        re_we = 1'b0; re_wa = r_cnt[RW-1:0]; re_wd = {i_item.w, i_item.h};
        re_ra = '0;
        or_we = 1'b0; or_wa = '0; or_wd = '0; or_ra = '0;
        sl_we = 1'b0; sl_wa = '0; sl_wd = pend; sl_ra = r_si[SW-1:0];
        case (r_st)
            S_IDLE: begin
                re_we = i_valid && o_ready && (r_cnt != rpg_pkg::RcntW'(rpg_pkg::MaxRects));
            end
            S_SORT_RD: begin
                re_ra = r_j[RW-1:0];
                or_ra = RW'(r_j - 1'b1);
            end
            S_SORT_CMP: begin
                re_ra = or_rd;
                or_ra = RW'(r_j - 1'b1);
            end
            S_SORT_WR: begin
                or_we = 1'b1;
                or_wa = r_j[RW-1:0];
                or_wd = (ld_area >= r_akey || r_j == '0) ? r_i[RW-1:0] : or_rd;
            end
            S_INIT: or_ra = '0;
            S_INIT2: re_ra = or_rd;
            S_BOOT: begin
                sl_we = boot_nz;
                sl_wa = '0;
                sl_wd = {32'd0, 16'(re_rd[19:10]), 16'(re_rd[9:0])};
            end
            S_RECT: or_ra = r_k[RW-1:0];
            S_RECT2: re_ra = or_rd;
            S_RECT3: sl_ra = '0;
            S_SHIFT: sl_ra = SW'(r_si + 1'b1);
            S_SHIFT2: begin
                sl_we = 1'b1; sl_wa = r_si[SW-1:0]; sl_wd = sl_rd;
                sl_ra = SW'(r_si + 2'd2);
            end
            S_PUSH: begin
                sl_we = (pend[31:16] != 16'd0) && (pend[15:0] != 16'd0)
                        && (r_scnt != rpg_pkg::ScntW'(rpg_pkg::MaxSlots));
                sl_wa = r_scnt[SW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_vout <= 1'b0;
            r_scnt <= '0; r_bw <= '0; r_bh <= '0;
        end else begin
            if (r_vout && i_ready) r_vout <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    if (r_cnt != rpg_pkg::RcntW'(rpg_pkg::MaxRects))
                        r_cnt <= r_cnt + 1'b1;
                    if (i_item.last) begin
                        r_i <= '0; r_j <= '0;
                        r_st <= S_SORT_RD;
                    end
                end
                S_SORT_RD: r_st <= S_SORT_CMP;
                S_SORT_CMP: begin
                    if (r_j == r_i) r_akey <= ld_area;
                    r_st <= S_SORT_WR;
                end
                S_SORT_WR: begin
                    // insertion step: shift predecessor up or drop key in
                    if (r_j == '0 || ld_area >= r_akey) begin
                        if (r_i + 1'b1 >= r_cnt) r_st <= S_INIT;
                        else begin
                            r_i <= r_i + 1'b1; r_j <= r_i + 1'b1;
                            r_st <= S_SORT_RD;
                        end
                    end else begin
                        r_j <= r_j - 1'b1;
                        r_st <= S_SORT_RD;
                    end
                end
                S_INIT: r_st <= S_INIT2;
                S_INIT2: r_st <= S_BOOT;
                S_BOOT: begin
                    // atlas starts as the largest rect, which is also the first slot
                    r_bw <= 16'(re_rd[19:10]); r_bh <= 16'(re_rd[9:0]);
                    r_scnt <= boot_nz ? NW'(1) : '0;
                    r_k <= '0;
                    r_st <= S_RECT;
                end
                S_RECT: r_st <= S_RECT2;
                S_RECT2: begin
                    r_id <= or_rd;
                    r_st <= S_RECT3;
                end
                S_RECT3: begin
                    r_rw <= 16'(re_rd[19:10]); r_rh <= 16'(re_rd[9:0]);
                    r_si <= NW'(1); r_found <= 1'b0; r_ovf <= 1'b0;
                    r_st <= (r_scnt == '0) ? S_DEC : S_SCAN;
                end
                S_SCAN: begin
                    // slot r_si-1 is on sl_rd
                    r_si <= r_si + 1'b1;
                    if (r_rw <= sl_rd[31:16] && r_rh <= sl_rd[15:0]) begin
                        r_found <= 1'b1;
                        if (!r_found || slot_area < r_barea) begin
                            r_best <= r_si - 1'b1;
                            r_barea <= slot_area;
                            {r_sx, r_sy, r_sw, r_sh} <= sl_rd;
                        end
                    end
                    if (r_si == r_scnt) r_st <= S_DEC;
                end
                S_DEC: begin
                    r_pi <= 2'd0;
                    if (r_found) begin
                        r_px <= r_sx; r_py <= r_sy;
                        r_p0 <= {rpg_pkg::sat16(17'(r_sx) + 17'(r_rw)), r_sy,
                                 r_sw - r_rw, r_sh};
                        r_p1 <= {r_sx, rpg_pkg::sat16(17'(r_sy) + 17'(r_rh)),
                                 r_rw, r_sh - r_rh};
                        r_pn <= 2'd2;
                        r_si <= r_best;
                        r_st <= S_SHIFT;
                    end else if (sq_r < sq_b && r_rh <= r_bh) begin
                        r_px <= r_bw; r_py <= '0;
                        r_p0 <= {r_bw, r_rh, r_rw, r_bh - r_rh};
                        r_pn <= 2'd1;
                        r_bw <= rpg_pkg::sat16(ew);
                        r_st <= S_PUSH;
                    end else begin
                        r_px <= '0; r_py <= r_bh;
                        r_p0 <= {r_rw, r_bh, (r_bw > r_rw) ? r_bw - r_rw : 16'd0, r_rh};
                        r_pn <= 2'd1;
                        r_bw <= (r_bw > r_rw) ? r_bw : r_rw;
                        r_bh <= rpg_pkg::sat16(eh);
                        r_st <= S_PUSH;
                    end
                end
                S_SHIFT: begin
                    if (r_si + 1'b1 >= r_scnt) begin
                        r_scnt <= r_scnt - 1'b1; r_st <= S_PUSH;
                    end else r_st <= S_SHIFT2;
                end
                S_SHIFT2: begin
                    r_si <= r_si + 1'b1;
                    if (r_si + 2'd2 >= r_scnt) begin
                        r_scnt <= r_scnt - 1'b1; r_st <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (pend[31:16] != 16'd0 && pend[15:0] != 16'd0) begin
                        if (r_scnt == rpg_pkg::ScntW'(rpg_pkg::MaxSlots)) r_ovf <= 1'b1;
                        else r_scnt <= r_scnt + 1'b1;
                    end
                    r_pi <= r_pi + 1'b1;
                    if (r_pi + 1'b1 >= r_pn) r_st <= S_OUT;
                end
                S_OUT: if (!r_vout) begin
                    r_vout <= 1'b1;
                    r_res <= '{idx: 6'(r_id), px: r_px, py: r_py, aw: r_bw, ah: r_bh,
                               ovf: r_ovf, last: (r_k + 1'b1 == r_cnt)};
                    if (r_k + 1'b1 == r_cnt) begin
                        r_cnt <= '0; r_st <= S_IDLE;
                    end else begin
                        r_k <= r_k + 1'b1; r_st <= S_RECT;
                    end
                end
                default: ;
            endcase
        end
    end

    `include "rect_pack_guillotine_best_area_unit_defines.svh"
    `RPG_ASSERT_IMP(a_scnt_cap, r_st == S_SCAN, r_scnt <= rpg_pkg::ScntW'(rpg_pkg::MaxSlots))
    `RPG_ASSERT_IMP(a_out_hold, r_vout && !i_ready, r_st != S_IDLE || r_cnt == '0)
    `RPG_ASSERT_NXT(a_out_set, r_st == S_OUT && !r_vout, r_vout)
endmodule

### design/rect_pack_guillotine_best_area_unit.sv
// top level of the guillotine best-area rectangle packer
// Rectangles load one per transaction, up to one per cycle through a two-entry
// input queue; the transaction with tlast set starts packing. The area sort is an
// insertion sort whose inner step walks S_SORT_RD, S_SORT_CMP and S_SORT_WR,
// followed by S_INIT, S_INIT2 and S_BOOT, which seed the atlas. Each placement
// then fetches the rectangle in S_RECT, S_RECT2 and S_RECT3, scans every stored
// free slot in S_SCAN through the single slot memory read port, decides in S_DEC,
// removes a used slot by moving later slots down in S_SHIFT and S_SHIFT2, pushes
// one or two new free slots in S_PUSH and hands the result over in S_OUT, which
// waits while the previous result is still held or the receiver stalls. While a
// set is packed the queue still takes up to two rectangles; the core takes the
// next set only after the last result of the current set has been handed off.
module rect_pack_guillotine_best_area_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // rect_width, rect_height
    input  logic        s_axis_tlast,  // last_rect
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // rect_index, pos_x, pos_y, atlas_width, atlas_height
    output logic [0:0]  m_axis_tuser,  // slot_overflow
    output logic        m_axis_tlast   // last_result
);
    logic q_valid, q_ready;
    rpg_pkg::t_item q_item;
    rpg_pkg::t_result res;

    rpg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_w(s_axis_tdata[9:0]), .i_h(s_axis_tdata[19:10]),
        .i_last(s_axis_tlast), .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item));

    rpg_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_item(q_item), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res));

    assign m_axis_tdata = {2'b00, res.ah, res.aw, res.py, res.px, res.idx};
    assign m_axis_tuser = res.ovf;
    assign m_axis_tlast = res.last;
endmodule
